// ===== rtl/sga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sga_pkg;

  localparam int TICKS_PER_FRAME_DEF = 6;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_POLL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROUTE_OFF = 2'd0,
    ROUTE_NMI = 2'd1,
    ROUTE_INT = 2'd2,
    ROUTE_RSV = 2'd3
  } route_t;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_NMI  = 2'd1;
  localparam logic [1:0] REQ_INT  = 2'd2;

  localparam logic [7:0] PORT_STATUS = 8'hF4;
  localparam logic [7:0] PORT_ROLLER = 8'hF5;
  localparam logic [7:0] PORT_SCROLL = 8'hF6;
  localparam logic [7:0] PORT_CTRL   = 8'hF7;
  localparam logic [7:0] PORT_CMD    = 8'hF8;

  localparam logic [7:0] CMD_BOOT_END  = 8'h00;
  localparam logic [7:0] CMD_ROUTE_NMI = 8'h02;
  localparam logic [7:0] CMD_ROUTE_INT = 8'h03;
  localparam logic [7:0] CMD_ROUTE_OFF = 8'h04;
  localparam logic [7:0] CMD_TC_SET    = 8'h05;
  localparam logic [7:0] CMD_TC_CLR    = 8'h06;
  localparam logic [7:0] CMD_DISP_SET  = 8'h07;
  localparam logic [7:0] CMD_DISP_CLR  = 8'h08;
  localparam logic [7:0] CMD_MOTOR_ON  = 8'h09;
  localparam logic [7:0] CMD_MOTOR_OFF = 8'h0A;

  localparam logic [7:0] RDATA_UNUSED = 8'hFF;
  localparam logic [3:0] COUNT_MAX    = 4'hF;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    op_t        op;
    logic [7:0] port;
    logic [7:0] wdata;
    logic       fdc_irq;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [1:0] irq_request;
    logic       timer_int;
    logic [7:0] roller_base_out;
    logic [7:0] scroll_out;
    logic       screen_on;
    logic       inverse_on;
    logic       display_on;
    logic       boot_finish;
    logic       terminal_count;
    logic       motor_on;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sga_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sga_in_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sga_pkg::item_t   in_item,
  input  wire logic             adv,
  output logic                  item_valid,
  output sga_pkg::item_t        item
);
  import sga_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_ready   = !vld_r || adv;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sga_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sga_regs #(
  parameter int TICKS_PER_FRAME = sga_pkg::TICKS_PER_FRAME_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire sga_pkg::item_t   item,
  output sga_pkg::result_t      res
);
  import sga_pkg::*;

  localparam int PW = (TICKS_PER_FRAME > 2) ? $clog2(TICKS_PER_FRAME) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(TICKS_PER_FRAME - 1);

  logic [7:0]    roller_r, roller_nxt;
  logic [7:0]    scroll_r, scroll_nxt;
  logic          screen_r, screen_nxt;
  logic          inverse_r, inverse_nxt;
  logic          display_r, display_nxt;
  logic [3:0]    count_r, count_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic          flyback_r, flyback_nxt;
  route_t        route_r, route_nxt;
  logic          prev_irq_r, prev_irq_nxt;
  logic          tc_r, tc_nxt;
  logic          motor_r, motor_nxt;

  logic [7:0] status;
  logic [7:0] rdata;
  logic [1:0] req;
  logic       tint;
  logic       boot;

  assign status = {1'b0, flyback_r, item.fdc_irq, 1'b0, count_r};

  always_comb begin
    roller_nxt   = roller_r;
    scroll_nxt   = scroll_r;
    screen_nxt   = screen_r;
    inverse_nxt  = inverse_r;
    display_nxt  = display_r;
    count_nxt    = count_r;
    phase_nxt    = phase_r;
    flyback_nxt  = flyback_r;
    route_nxt    = route_r;
    prev_irq_nxt = prev_irq_r;
    tc_nxt       = tc_r;
    motor_nxt    = motor_r;
    rdata        = 8'h00;
    req          = REQ_NONE;
    tint         = 1'b0;
    boot         = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 4'd1;
        end
        phase_nxt   = (phase_r == PHASE_LAST) ? '0 : phase_r + PW'(1);
        flyback_nxt = (phase_nxt == PHASE_LAST);
        tint        = 1'b1;
      end
      OP_READ: begin
        if (item.port == PORT_STATUS) begin
          rdata     = status;
          count_nxt = 4'd0;
        end else if (item.port == PORT_CMD) begin
          rdata = status;
        end else begin
          rdata = RDATA_UNUSED;
        end
      end
      OP_WRITE: begin
        unique case (item.port)
          PORT_ROLLER: roller_nxt = item.wdata;
          PORT_SCROLL: scroll_nxt = item.wdata;
          PORT_CTRL: begin
            screen_nxt  = item.wdata[6];
            inverse_nxt = item.wdata[7];
          end
          PORT_CMD: begin
            unique case (item.wdata)
              CMD_BOOT_END:  boot = 1'b1;
              CMD_ROUTE_NMI: begin
                route_nxt    = ROUTE_NMI;
                prev_irq_nxt = 1'b0;
              end
              CMD_ROUTE_INT: begin
                route_nxt    = ROUTE_INT;
                prev_irq_nxt = 1'b0;
              end
              CMD_ROUTE_OFF: route_nxt   = ROUTE_OFF;
              CMD_TC_SET:    tc_nxt      = 1'b1;
              CMD_TC_CLR:    tc_nxt      = 1'b0;
              CMD_DISP_SET:  display_nxt = 1'b1;
              CMD_DISP_CLR:  display_nxt = 1'b0;
              CMD_MOTOR_ON:  motor_nxt   = 1'b1;
              CMD_MOTOR_OFF: motor_nxt   = 1'b0;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      OP_POLL: begin
        if (route_r == ROUTE_INT && item.fdc_irq) begin
          req = REQ_INT;
        end else if (route_r == ROUTE_NMI && item.fdc_irq && !prev_irq_r) begin
          req = REQ_NMI;
        end
        prev_irq_nxt = item.fdc_irq;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.rdata           = rdata;
    res.irq_request     = req;
    res.timer_int       = tint;
    res.roller_base_out = roller_nxt;
    res.scroll_out      = scroll_nxt;
    res.screen_on       = screen_nxt;
    res.inverse_on      = inverse_nxt;
    res.display_on      = display_nxt;
    res.boot_finish     = boot;
    res.terminal_count  = tc_nxt;
    res.motor_on        = motor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roller_r   <= 8'h00;
      scroll_r   <= 8'h00;
      screen_r   <= 1'b1;
      inverse_r  <= 1'b0;
      display_r  <= 1'b1;
      count_r    <= 4'd0;
      phase_r    <= '0;
      flyback_r  <= 1'b0;
      route_r    <= ROUTE_OFF;
      prev_irq_r <= 1'b0;
      tc_r       <= 1'b0;
      motor_r    <= 1'b0;
    end else if (adv) begin
      roller_r   <= roller_nxt;
      scroll_r   <= scroll_nxt;
      screen_r   <= screen_nxt;
      inverse_r  <= inverse_nxt;
      display_r  <= display_nxt;
      count_r    <= count_nxt;
      phase_r    <= phase_nxt;
      flyback_r  <= flyback_nxt;
      route_r    <= route_nxt;
      prev_irq_r <= prev_irq_nxt;
      tc_r       <= tc_nxt;
      motor_r    <= motor_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sga_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sga_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire sga_pkg::result_t  res,
  output logic                   adv,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sga_pkg::result_t       out_res
);
  import sga_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign adv       = item_valid && (!vld_r || out_ready);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_ready) begin
      vld_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/system_gate_array_regs_core.sv =====
// Gate array register block: ticks, port reads/writes and floppy interrupt polls.
// Pipeline: input register, then result register; an item waits in the input register while the output stalls.
// Throughput: one item per cycle while out_tready allows; register state updates as an item enters the result register.
// Reset: rst_n synchronous active low; clears both stages and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none

module system_gate_array_regs_core #(
  parameter int TICKS_PER_FRAME = sga_pkg::TICKS_PER_FRAME_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // port[7:0], wdata[15:8], fdc_irq[16], zero[23:17]
  input  wire logic [sga_pkg::IN_DATA_W-1:0]      in_tdata,
  // op[1:0]
  input  wire logic [1:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // rdata[7:0], irq_request[9:8], timer_int[10], roller_base_out[18:11],
  // scroll_out[26:19], screen_on[27], inverse_on[28], display_on[29],
  // boot_finish[30], terminal_count[31], motor_on[32], zero[39:33]
  output logic [sga_pkg::OUT_DATA_W-1:0]          out_tdata
);
  import sga_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    adv;
  result_t res;
  result_t out_res;

  assign in_item.op      = op_t'(in_tuser);
  assign in_item.port    = in_tdata[7:0];
  assign in_item.wdata   = in_tdata[15:8];
  assign in_item.fdc_irq = in_tdata[16];

  sga_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  sga_regs #(
    .TICKS_PER_FRAME (TICKS_PER_FRAME)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  sga_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .adv        (adv),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0,
                      out_res.motor_on,
                      out_res.terminal_count,
                      out_res.boot_finish,
                      out_res.display_on,
                      out_res.inverse_on,
                      out_res.screen_on,
                      out_res.scroll_out,
                      out_res.roller_base_out,
                      out_res.timer_int,
                      out_res.irq_request,
                      out_res.rdata};

endmodule

`default_nettype wire

// ===== tb/sga_regs_checker.sv =====
`timescale 1ns / 1ps

module sga_regs_checker #(
  parameter int TICKS_PER_FRAME = sga_pkg::TICKS_PER_FRAME_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  // port[7:0], wdata[15:8], fdc_irq[16], zero[23:17]
  input  wire logic [sga_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [1:0]                     in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // rdata[7:0], irq_request[9:8], timer_int[10], roller_base_out[18:11],
  // scroll_out[26:19], screen_on[27], inverse_on[28], display_on[29],
  // boot_finish[30], terminal_count[31], motor_on[32], zero[39:33]
  input  wire logic [sga_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  checked
);
  import sga_pkg::*;

  logic [7:0] roller;
  logic [7:0] vscroll;
  logic       screen_en;
  logic       inverse_en;
  logic       display_en;
  logic [3:0] irq_count;
  int         phase;
  logic       flyback;
  route_t     route;
  logic       last_irq;
  logic       tc;
  logic       motor;

  result_t expected_q[$];
  int      errs;
  int      n_checked;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    errs       = 0;
    n_checked  = 0;
  end

  task automatic reset_regs();
    roller     = '0;
    vscroll    = '0;
    screen_en  = 1'b1;
    inverse_en = 1'b0;
    display_en = 1'b1;
    irq_count  = '0;
    phase      = 0;
    flyback    = 1'b0;
    route      = ROUTE_OFF;
    last_irq   = 1'b0;
    tc         = 1'b0;
    motor      = 1'b0;
  endtask

  function automatic logic [7:0] status_of(input logic line);
    logic [7:0] v;
    v    = {4'd0, irq_count};
    v[6] = flyback;
    v[5] = line;
    return v;
  endfunction

  task automatic advance_regs(input item_t it, output result_t res);
    res = '0;
    case (it.op)
      OP_TICK: begin
        if (irq_count != COUNT_MAX) irq_count = irq_count + 4'd1;
        phase         = (phase + 1) % TICKS_PER_FRAME;
        flyback       = (phase == TICKS_PER_FRAME - 1);
        res.timer_int = 1'b1;
      end
      OP_READ: begin
        if (it.port == PORT_STATUS) begin
          res.rdata = status_of(it.fdc_irq);
          irq_count = '0;
        end else if (it.port == PORT_CMD) begin
          res.rdata = status_of(it.fdc_irq);
        end else begin
          res.rdata = RDATA_UNUSED;
        end
      end
      OP_WRITE: begin
        case (it.port)
          PORT_ROLLER: roller = it.wdata;
          PORT_SCROLL: vscroll = it.wdata;
          PORT_CTRL: begin
            screen_en  = it.wdata[6];
            inverse_en = it.wdata[7];
          end
          PORT_CMD: begin
            case (it.wdata)
              CMD_BOOT_END: res.boot_finish = 1'b1;
              CMD_ROUTE_NMI: begin
                route    = ROUTE_NMI;
                last_irq = 1'b0;
              end
              CMD_ROUTE_INT: begin
                route    = ROUTE_INT;
                last_irq = 1'b0;
              end
              CMD_ROUTE_OFF: route = ROUTE_OFF;
              CMD_TC_SET:    tc = 1'b1;
              CMD_TC_CLR:    tc = 1'b0;
              CMD_DISP_SET:  display_en = 1'b1;
              CMD_DISP_CLR:  display_en = 1'b0;
              CMD_MOTOR_ON:  motor = 1'b1;
              CMD_MOTOR_OFF: motor = 1'b0;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: begin
        if (route == ROUTE_INT && it.fdc_irq) begin
          res.irq_request = REQ_INT;
        end else if (route == ROUTE_NMI && it.fdc_irq && !last_irq) begin
          res.irq_request = REQ_NMI;
        end
        last_irq = it.fdc_irq;
      end
    endcase
    res.roller_base_out = roller;
    res.scroll_out      = vscroll;
    res.screen_on       = screen_en;
    res.inverse_on      = inverse_en;
    res.display_on      = display_en;
    res.terminal_count  = tc;
    res.motor_on        = motor;
  endtask

  function automatic result_t unpack_result(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.rdata           = d[7:0];
    r.irq_request     = d[9:8];
    r.timer_int       = d[10];
    r.roller_base_out = d[18:11];
    r.scroll_out      = d[26:19];
    r.screen_on       = d[27];
    r.inverse_on      = d[28];
    r.display_on      = d[29];
    r.boot_finish     = d[30];
    r.terminal_count  = d[31];
    r.motor_on        = d[32];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  task automatic compare_result(input result_t want, input result_t got);
    check_field("rdata", want.rdata, got.rdata);
    check_field("irq_request", 8'(want.irq_request), 8'(got.irq_request));
    check_field("timer_int", 8'(want.timer_int), 8'(got.timer_int));
    check_field("roller_base_out", want.roller_base_out, got.roller_base_out);
    check_field("scroll_out", want.scroll_out, got.scroll_out);
    check_field("screen_on", 8'(want.screen_on), 8'(got.screen_on));
    check_field("inverse_on", 8'(want.inverse_on), 8'(got.inverse_on));
    check_field("display_on", 8'(want.display_on), 8'(got.display_on));
    check_field("boot_finish", 8'(want.boot_finish), 8'(got.boot_finish));
    check_field("terminal_count", 8'(want.terminal_count), 8'(got.terminal_count));
    check_field("motor_on", 8'(want.motor_on), 8'(got.motor_on));
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    result_t predicted;
    if (!rst_n) begin
      reset_regs();
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata);
        if (expected_q.size() == 0) begin
          errs++;
          $error("result with no item outstanding: tdata 0x%0h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          compare_result(want, got);
          n_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        it.op      = op_t'(in_tuser);
        it.port    = in_tdata[7:0];
        it.wdata   = in_tdata[15:8];
        it.fdc_irq = in_tdata[16];
        advance_regs(it, predicted);
        expected_q.push_back(predicted);
      end
    end
    mismatches <= errs;
    pending    <= expected_q.size();
    checked    <= n_checked;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sga_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ITEMS = 1150;
  localparam logic [7:0] CMD_RSV_LO   = 8'h01;
  localparam logic [7:0] CMD_RSV_HI   = 8'h0B;
  localparam logic [7:0] PORT_IDLE_LO = 8'h00;
  localparam logic [7:0] PORT_IDLE_HI = 8'hFF;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tready = 1'b0;
  wire logic             in_tready;
  wire logic             out_tvalid;
  wire logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int checked;
  int cycles     = 0;
  int items_sent = 0;
  int ready_hold = 0;
  int op_count[4] = '{0, 0, 0, 0};
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  always #1 clk = ~clk;

  system_gate_array_regs_core #(
    .TICKS_PER_FRAME(TICKS_PER_FRAME_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sga_regs_checker #(
    .TICKS_PER_FRAME(TICKS_PER_FRAME_DEF)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("system_gate_array_regs_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 6);
      out_tready <= (stall == 0);
      ready_hold <= stall;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= (ready_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 12))
      0:       return CMD_BOOT_END;
      1:       return CMD_ROUTE_NMI;
      2:       return CMD_ROUTE_INT;
      3:       return CMD_ROUTE_OFF;
      4:       return CMD_TC_SET;
      5:       return CMD_TC_CLR;
      6:       return CMD_DISP_SET;
      7:       return CMD_DISP_CLR;
      8:       return CMD_MOTOR_ON;
      9:       return CMD_MOTOR_OFF;
      10:      return CMD_RSV_LO;
      default: return rand_byte();
    endcase
  endfunction

  function automatic logic [7:0] pick_port();
    case ($urandom_range(0, 5))
      0:       return PORT_STATUS;
      1:       return PORT_ROLLER;
      2:       return PORT_SCROLL;
      3:       return PORT_CTRL;
      4:       return PORT_CMD;
      default: return rand_byte();
    endcase
  endfunction

  task automatic send(input op_t op, input logic [7:0] port, input logic [7:0] wdata,
                      input logic irq);
    int gap;
    if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, irq, wdata, port};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    op_count[op]++;
    items_sent++;
  endtask

  initial begin
    int first_random;
    int n;
    logic [7:0] wport;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_READ, PORT_STATUS, 8'hFF, 1'b1);
    send(OP_READ, PORT_CMD, 8'h00, 1'b0);
    send(OP_READ, PORT_IDLE_HI, 8'hFF, 1'b1);
    send(OP_WRITE, PORT_ROLLER, 8'hFF, 1'b0);
    send(OP_WRITE, PORT_SCROLL, 8'hFF, 1'b1);
    send(OP_WRITE, PORT_CTRL, 8'hC0, 1'b0);
    send(OP_WRITE, PORT_IDLE_LO, 8'hFF, 1'b1);
    send(OP_WRITE, PORT_CMD, CMD_BOOT_END, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_RSV_LO, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_RSV_HI, 1'b0);
    // routing off: no request, level still remembered
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_WRITE, PORT_CMD, CMD_ROUTE_NMI, 1'b1);
    send(OP_POLL, PORT_IDLE_HI, 8'hFF, 1'b1);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b0);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_WRITE, PORT_CMD, CMD_ROUTE_INT, 1'b0);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_WRITE, PORT_CMD, CMD_ROUTE_OFF, 1'b0);
    send(OP_POLL, PORT_IDLE_LO, 8'h00, 1'b1);
    send(OP_WRITE, PORT_CMD, CMD_TC_SET, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_DISP_CLR, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_MOTOR_ON, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_TC_CLR, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_DISP_SET, 1'b0);
    send(OP_WRITE, PORT_CMD, CMD_MOTOR_OFF, 1'b0);

    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // tick run that can be long enough to saturate the counter and wrap the frame
          n = $urandom_range(1, 20);
          repeat (n) send(OP_TICK, rand_byte(), rand_byte(), rand_bit());
          send(OP_READ, $urandom_range(0, 1) ? PORT_STATUS : PORT_CMD, rand_byte(),
               rand_bit());
        end
        3, 4: begin
          if ($urandom_range(0, 3) == 0) begin
            send(OP_WRITE, PORT_CMD, CMD_ROUTE_OFF, rand_bit());
          end else begin
            send(OP_WRITE, PORT_CMD,
                 $urandom_range(0, 1) ? CMD_ROUTE_NMI : CMD_ROUTE_INT, rand_bit());
          end
          n = $urandom_range(1, 8);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
              send(OP_READ, PORT_CMD, rand_byte(), rand_bit());
            end else begin
              send(OP_POLL, rand_byte(), rand_byte(), rand_bit());
            end
          end
        end
        5, 6: begin
          case ($urandom_range(0, 3))
            0:       wport = PORT_ROLLER;
            1:       wport = PORT_SCROLL;
            2:       wport = PORT_CTRL;
            default: wport = PORT_CMD;
          endcase
          send(OP_WRITE, wport, wport == PORT_CMD ? pick_command() : rand_byte(),
               rand_bit());
        end
        7: send(OP_READ, pick_port(), rand_byte(), rand_bit());
        default: send(op_t'($urandom_range(0, 3)), pick_port(), rand_byte(), rand_bit());
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d items: %0d ticks, %0d reads, %0d writes, %0d polls.",
             items_sent, op_count[OP_TICK], op_count[OP_READ], op_count[OP_WRITE],
             op_count[OP_POLL]);
    $display("Compared %0d results field by field, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("system_gate_array_regs_core regression: pass");
    end else begin
      $display("system_gate_array_regs_core regression: fail");
    end
    $finish;
  end

endmodule
